// File: design/mcr_pkg.sv
// shared types and constants for the midpoint circle rasterizer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mcr_pkg;

	// default widths, used as the defaults of the top level parameters
	localparam int COORD_BITS_DEF  = 12;
	localparam int RADIUS_BITS_DEF = 10;

	// depth of the job queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// action codes of an input beat
	localparam logic ACTION_START = 1'b0;
	localparam logic ACTION_STEP  = 1'b1;

	// what the back end has to emit for one job
	typedef enum logic [1:0] {
		JOB_EMPTY = 2'd0,
		JOB_AXIS  = 2'd1,
		JOB_OCT   = 2'd2
	} job_kind_t;

	// control part of a job; done marks the job that completes the circle
	typedef struct packed {
		job_kind_t kind;
		logic      done;
	} job_ctrl_t;

endpackage

// File: design/mcr_front.sv
// front end: accepts input beats, runs one midpoint iteration per step
// and pushes a classified job; depends on mcr_pkg
`timescale 1ns / 1ps

module mcr_front import mcr_pkg::*; #(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic signed [COORD_BITS-1:0]  centre_x,
	input  logic signed [COORD_BITS-1:0]  centre_y,
	input  logic        [RADIUS_BITS-1:0] circle_radius,
	input  logic                          queue_full,
	output logic                          job_push,
	output job_ctrl_t                     job_ctrl,
	output logic signed [COORD_BITS-1:0]  job_cx,
	output logic signed [COORD_BITS-1:0]  job_cy,
	output logic        [RADIUS_BITS-1:0] job_ox,
	output logic        [RADIUS_BITS-1:0] job_oy
);

	localparam int DEC_W = RADIUS_BITS + 4;

	logic signed [COORD_BITS-1:0]  centre_x_q;
	logic signed [COORD_BITS-1:0]  centre_y_q;
	logic        [RADIUS_BITS-1:0] offset_x_q;
	logic        [RADIUS_BITS-1:0] offset_y_q;
	logic        [DEC_W-1:0]       decision_q;
	logic                          active_q;

	logic                          accept;
	logic                          dec_pos;
	logic        [RADIUS_BITS:0]   oy_n;
	logic        [RADIUS_BITS:0]   ox_n;
	logic        [DEC_W-1:0]       dec_n;
	logic                          overshoot;
	logic                          diag;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;
	assign job_push = accept;

	// one midpoint iteration from the stored state
	always_comb begin
		dec_pos   = !decision_q[DEC_W-1] && (decision_q != '0);
		oy_n      = {1'b0, offset_y_q} + 1'b1;
		ox_n      = dec_pos ? ({1'b0, offset_x_q} - 1'b1) : {1'b0, offset_x_q};
		dec_n     = decision_q + {{(DEC_W-RADIUS_BITS-2){1'b0}}, oy_n, 1'b1}
			- (dec_pos ? {{(DEC_W-RADIUS_BITS-2){1'b0}}, ox_n, 1'b0} : '0);
		overshoot = ox_n < oy_n;
		diag      = ox_n == oy_n;
	end

	// classify the beat into a job
	always_comb begin
		job_ctrl.kind = JOB_EMPTY;
		job_ctrl.done = 1'b1;
		job_cx        = centre_x_q;
		job_cy        = centre_y_q;
		job_ox        = ox_n[RADIUS_BITS-1:0];
		job_oy        = oy_n[RADIUS_BITS-1:0];
		if (action == ACTION_START) begin
			job_cx = centre_x;
			job_cy = centre_y;
			job_ox = circle_radius;
			job_oy = '0;
			if (circle_radius != '0) begin
				job_ctrl.kind = JOB_AXIS;
				job_ctrl.done = 1'b0;
			end
		end else if (active_q && !overshoot) begin
			job_ctrl.kind = JOB_OCT;
			job_ctrl.done = diag;
		end
	end

	// circle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q <= '0;
			centre_y_q <= '0;
			offset_x_q <= '0;
			offset_y_q <= '0;
			decision_q <= '0;
			active_q   <= 1'b0;
		end else if (accept) begin
			if (action == ACTION_START) begin
				centre_x_q <= centre_x;
				centre_y_q <= centre_y;
				offset_x_q <= circle_radius;
				offset_y_q <= '0;
				decision_q <= DEC_W'(1) - {{(DEC_W-RADIUS_BITS){1'b0}}, circle_radius};
				active_q   <= circle_radius != '0;
			end else if (active_q) begin
				offset_x_q <= ox_n[RADIUS_BITS-1:0];
				offset_y_q <= oy_n[RADIUS_BITS-1:0];
				decision_q <= dec_n;
				active_q   <= !overshoot && !diag;
			end
		end
	end

endmodule

// File: design/mcr_queue.sv
// small job queue between front and back ends
// depends on mcr_pkg for its depth
`timescale 1ns / 1ps

module mcr_queue import mcr_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = count_q == CNT_W'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data  = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/mcr_back.sv
// back end: expands one job into its result beats, one per cycle
// while not stalled, via an output register; depends on mcr_pkg
`timescale 1ns / 1ps

module mcr_back import mcr_pkg::*; #(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	input  job_ctrl_t                     job_ctrl,
	input  logic signed [COORD_BITS-1:0]  job_cx,
	input  logic signed [COORD_BITS-1:0]  job_cy,
	input  logic        [RADIUS_BITS-1:0] job_ox,
	input  logic        [RADIUS_BITS-1:0] job_oy,
	output logic                          job_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_BITS:0]    point_x,
	output logic signed [COORD_BITS:0]    point_y,
	output logic                          empty_res,
	output logic                          last,
	output logic                          done_res
);

	localparam int SUM_W = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

	logic                          cur_valid_q;
	job_ctrl_t                     cur_ctrl_q;
	logic signed [COORD_BITS-1:0]  cur_cx_q;
	logic signed [COORD_BITS-1:0]  cur_cy_q;
	logic        [RADIUS_BITS-1:0] cur_ox_q;
	logic        [RADIUS_BITS-1:0] cur_oy_q;
	logic        [2:0]             idx_q;

	logic                          out_valid_q;
	logic signed [COORD_BITS:0]    point_x_q;
	logic signed [COORD_BITS:0]    point_y_q;
	logic                          empty_q;
	logic                          last_q;
	logic                          done_q;

	logic                          out_adv;
	logic                          is_last;
	logic                          load_job;
	logic        [RADIUS_BITS-1:0] mag_x;
	logic        [RADIUS_BITS-1:0] mag_y;
	logic                          neg_x;
	logic                          neg_y;
	logic        [SUM_W-1:0]       dx;
	logic        [SUM_W-1:0]       dy;
	logic        [SUM_W-1:0]       sum_x;
	logic        [SUM_W-1:0]       sum_y;

	assign out_adv  = !out_valid_q || !out_stall;
	assign load_job = job_valid && (!cur_valid_q || (out_adv && is_last));
	assign job_pop  = load_job;

	// position of the final beat of the current job
	always_comb begin
		case (cur_ctrl_q.kind)
			JOB_EMPTY: is_last = idx_q == 3'd0;
			JOB_AXIS:  is_last = idx_q == 3'd3;
			JOB_OCT:   is_last = cur_ctrl_q.done ? (idx_q == 3'd3) : (idx_q == 3'd7);
			default:   is_last = 1'b1;
		endcase
	end

	// offset of the current beat: axis points or octant reflections
	always_comb begin
		if (cur_ctrl_q.kind == JOB_AXIS) begin
			mag_x = idx_q[0] ? '0 : cur_ox_q;
			mag_y = idx_q[0] ? cur_ox_q : '0;
			neg_x = idx_q[1];
			neg_y = idx_q[1];
		end else begin
			mag_x = idx_q[2] ? cur_oy_q : cur_ox_q;
			mag_y = idx_q[2] ? cur_ox_q : cur_oy_q;
			neg_x = idx_q[0];
			neg_y = idx_q[1];
		end
		dx    = {{(SUM_W-RADIUS_BITS){1'b0}}, mag_x};
		dy    = {{(SUM_W-RADIUS_BITS){1'b0}}, mag_y};
		sum_x = {{(SUM_W-COORD_BITS){cur_cx_q[COORD_BITS-1]}}, cur_cx_q}
			+ (neg_x ? (~dx + 1'b1) : dx);
		sum_y = {{(SUM_W-COORD_BITS){cur_cy_q[COORD_BITS-1]}}, cur_cy_q}
			+ (neg_y ? (~dy + 1'b1) : dy);
	end

	// current job and beat index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load_job) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (cur_valid_q && out_adv) begin
				if (is_last) begin
					cur_valid_q <= 1'b0;
				end
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// job payload
	always_ff @(posedge clk) begin
		if (load_job) begin
			cur_ctrl_q <= job_ctrl;
			cur_cx_q   <= job_cx;
			cur_cy_q   <= job_cy;
			cur_ox_q   <= job_ox;
			cur_oy_q   <= job_oy;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= cur_valid_q;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_adv && cur_valid_q) begin
			if (cur_ctrl_q.kind == JOB_EMPTY) begin
				point_x_q <= '0;
				point_y_q <= '0;
				empty_q   <= 1'b1;
			end else begin
				point_x_q <= sum_x[COORD_BITS:0];
				point_y_q <= sum_y[COORD_BITS:0];
				empty_q   <= 1'b0;
			end
			last_q <= is_last;
			done_q <= is_last && cur_ctrl_q.done;
		end
	end

	assign out_valid = out_valid_q;
	assign point_x   = point_x_q;
	assign point_y   = point_y_q;
	assign empty_res = empty_q;
	assign last      = last_q;
	assign done_res  = done_q;

endmodule

// File: design/midpoint_circle_rasterizer.sv
// midpoint circle rasterizer: a beat passes the job queue, the back end's job register
// and the output register; results leave at one beat per cycle while out_stall is low;
// a step emits eight octant points (four on the diagonal), a start four axis points,
// empty results one beat; the front takes a new beat each cycle while the queue has room
// reset clears the queue, the output register and the circle state (no circle active)
`timescale 1ns / 1ps

module midpoint_circle_rasterizer import mcr_pkg::*; #(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic signed [COORD_BITS-1:0]  centre_x,
	input  logic signed [COORD_BITS-1:0]  centre_y,
	input  logic        [RADIUS_BITS-1:0] circle_radius,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_BITS:0]    point_x,
	output logic signed [COORD_BITS:0]    point_y,
	output logic                          empty_res,
	output logic                          last,
	output logic                          done_res
);

	localparam int CTRL_W = $bits(job_ctrl_t);
	localparam int JOB_W  = CTRL_W + 2 * COORD_BITS + 2 * RADIUS_BITS;

	logic                          queue_full;
	logic                          job_push;
	job_ctrl_t                     push_ctrl;
	logic signed [COORD_BITS-1:0]  push_cx;
	logic signed [COORD_BITS-1:0]  push_cy;
	logic        [RADIUS_BITS-1:0] push_ox;
	logic        [RADIUS_BITS-1:0] push_oy;
	logic        [JOB_W-1:0]       push_data;
	logic                          job_pop;
	logic                          pop_valid;
	logic        [JOB_W-1:0]       pop_data;
	job_ctrl_t                     pop_ctrl;

	// front end
	mcr_front #(
		.COORD_BITS (COORD_BITS),
		.RADIUS_BITS(RADIUS_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.centre_x     (centre_x),
		.centre_y     (centre_y),
		.circle_radius(circle_radius),
		.queue_full   (queue_full),
		.job_push     (job_push),
		.job_ctrl     (push_ctrl),
		.job_cx       (push_cx),
		.job_cy       (push_cy),
		.job_ox       (push_ox),
		.job_oy       (push_oy)
	);

	assign push_data = {push_ctrl, push_cx, push_cy, push_ox, push_oy};

	// job queue
	mcr_queue #(
		.WIDTH(JOB_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_data(push_data),
		.full     (queue_full),
		.pop      (job_pop),
		.pop_valid(pop_valid),
		.pop_data (pop_data)
	);

	assign pop_ctrl = job_ctrl_t'(pop_data[JOB_W-1 -: CTRL_W]);

	// back end
	mcr_back #(
		.COORD_BITS (COORD_BITS),
		.RADIUS_BITS(RADIUS_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(pop_valid),
		.job_ctrl (pop_ctrl),
		.job_cx   (pop_data[2*RADIUS_BITS+2*COORD_BITS-1 -: COORD_BITS]),
		.job_cy   (pop_data[2*RADIUS_BITS+COORD_BITS-1 -: COORD_BITS]),
		.job_ox   (pop_data[2*RADIUS_BITS-1 -: RADIUS_BITS]),
		.job_oy   (pop_data[RADIUS_BITS-1:0]),
		.job_pop  (job_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.point_x  (point_x),
		.point_y  (point_y),
		.empty_res(empty_res),
		.last     (last),
		.done_res (done_res)
	);

endmodule
